// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the encoder RTL.
// Depends on nothing; the checks vanish when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Antecedent true at an edge: consequent must hold at the same edge.
`define DGTE_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Antecedent true at an edge: consequent must hold at the next edge.
`define DGTE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define DGTE_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg)
`define DGTE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

// ===== rtl/dgte_pkg.sv =====
// Types, byte constants and digit helpers for the GeneralizedTime encoder.
// Depends on nothing; every RTL module imports it.
package dgte_pkg;

    localparam int FRAC_DIGITS = 10;
    localparam int YEAR_DIGITS = 4;

    // Tag, length byte and fourteen time digits come before any fraction.
    localparam logic [5:0] BASE_LEN  = 6'd16;
    localparam logic [4:0] POS_TAG   = 5'd0;
    localparam logic [4:0] POS_LEN   = 5'd1;
    localparam logic [4:0] POS_YEAR  = 5'd2;
    localparam logic [4:0] POS_PAIRS = 5'd6;
    localparam logic [4:0] POS_DOT   = 5'd16;
    localparam logic [4:0] POS_FRAC  = 5'd17;

    localparam logic [7:0] TAG_GENTIME = 8'h18;
    localparam logic [7:0] ASCII_ZERO  = 8'h30;
    localparam logic [7:0] ASCII_DOT   = 8'h2E;
    localparam logic [7:0] ASCII_Z     = 8'h5A;
    localparam logic [7:0] ASCII_PLUS  = 8'h2B;
    localparam logic [7:0] ASCII_MINUS = 8'h2D;

    localparam logic STATUS_OK    = 1'b0;
    localparam logic STATUS_SHORT = 1'b1;

    typedef logic [3:0] digit_t;

    typedef struct packed {
        logic [13:0] year;
        logic [6:0]  month;
        logic [6:0]  day;
        logic [6:0]  hour;
        logic [6:0]  minute;
        logic [6:0]  second;
        logic [31:0] fraction;
        logic        offset_negative;
        logic [6:0]  offset_hours;
        logic [6:0]  offset_minutes;
        logic [7:0]  buffer_space;
    } in_item_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       last;
        logic       status;
        logic [5:0] total_length;
    } out_item_t;

    // One classified record, handed from the front to the byte serialiser.
    typedef struct packed {
        digit_t [FRAC_DIGITS-1:0] frac_dig;   // least significant first
        logic [3:0]               frac_cnt;
        digit_t [YEAR_DIGITS-1:0] year_dig;   // least significant first
        logic [6:0]               month;
        logic [6:0]               day;
        logic [6:0]               hour;
        logic [6:0]               minute;
        logic [6:0]               second;
        logic [6:0]               off_hours;
        logic [6:0]               off_minutes;
        logic                     off_neg;
        logic                     has_frac;
        logic                     has_off;
        logic                     too_short;
        logic [5:0]               total;
    } job_t;

    typedef enum logic [1:0] {
        F_IDLE,
        F_FRAC,
        F_YEAR,
        F_PUSH
    } front_state_t;

    typedef enum logic {
        B_IDLE,
        B_EMIT
    } back_state_t;

    // Low two decimal digits of a 7-bit value: {tens, ones}.
    function automatic logic [7:0] two_digits(input logic [6:0] v);
        logic [14:0] prod;
        logic [3:0]  quot;
        logic [6:0]  ones;
        logic [3:0]  tens;
        prod = 15'(v) * 15'd205;
        quot = prod[14:11];
        ones = v - (7'({quot, 3'b000}) + 7'({quot, 1'b0}));
        tens = (quot >= 4'd10) ? (quot - 4'd10) : quot;
        return {tens, ones[3:0]};
    endfunction

    function automatic logic [7:0] digit_char(input digit_t d);
        return ASCII_ZERO | {4'b0000, d};
    endfunction

endpackage

// ===== rtl/dgte_front.sv =====
// Front part: takes one record, splits fraction and year into decimal digits
// with a shared divide-by-ten step, sizes the encoding. Depends on dgte_pkg.
`include "assert_macros.svh"
module dgte_front (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    output logic             full,
    input  dgte_pkg::in_item_t item,
    output logic             job_push,
    output dgte_pkg::job_t   job,
    input  logic             job_full
);
    import dgte_pkg::*;

    front_state_t             state_reg, state_next;
    in_item_t                 rec_reg, rec_next;
    logic [31:0]              work_reg, work_next;
    digit_t [FRAC_DIGITS-1:0] fdig_reg, fdig_next;
    logic [3:0]               nfd_reg, nfd_next;
    digit_t [YEAR_DIGITS-1:0] ydig_reg, ydig_next;
    logic [1:0]               ycnt_reg, ycnt_next;

    logic [63:0] prod;
    logic [31:0] quot;
    logic [31:0] rem;
    logic        has_frac;
    logic        has_off;
    logic [5:0]  total;

    // Divide by ten through the reciprocal; remainder by shift-add.
    assign prod = 64'(work_reg) * 64'(32'hCCCC_CCCD);
    assign quot = 32'(prod[63:35]);
    assign rem  = work_reg - ((quot << 3) + (quot << 1));

    assign has_frac = (rec_reg.fraction != 32'd0);
    assign has_off  = (rec_reg.offset_hours != 7'd0) || (rec_reg.offset_minutes != 7'd0);
    assign total    = BASE_LEN
                    + (has_frac ? (6'(nfd_reg) + 6'd1) : 6'd0)
                    + (has_off ? 6'd5 : 6'd1);

    always_comb
    begin
        job.frac_dig    = fdig_reg;
        job.frac_cnt    = nfd_reg;
        job.year_dig    = ydig_reg;
        job.month       = rec_reg.month;
        job.day         = rec_reg.day;
        job.hour        = rec_reg.hour;
        job.minute      = rec_reg.minute;
        job.second      = rec_reg.second;
        job.off_hours   = rec_reg.offset_hours;
        job.off_minutes = rec_reg.offset_minutes;
        job.off_neg     = rec_reg.offset_negative;
        job.has_frac    = has_frac;
        job.has_off     = has_off;
        job.too_short   = ({2'b00, total} > rec_reg.buffer_space);
        job.total       = total;
    end

    always_comb
    begin
        state_next = state_reg;
        rec_next   = rec_reg;
        work_next  = work_reg;
        fdig_next  = fdig_reg;
        nfd_next   = nfd_reg;
        ydig_next  = ydig_reg;
        ycnt_next  = ycnt_reg;
        full       = (state_reg != F_IDLE);
        job_push   = 1'b0;
        case (state_reg)
            F_IDLE:
            begin
                if (push)
                begin
                    rec_next   = item;
                    work_next  = item.fraction;
                    nfd_next   = 4'd0;
                    state_next = F_FRAC;
                end
            end
            F_FRAC:
            begin
                // Peel fraction digits until nothing is left.
                if (work_reg == 32'd0)
                begin
                    work_next  = 32'(rec_reg.year);
                    ycnt_next  = 2'd0;
                    state_next = F_YEAR;
                end
                else
                begin
                    fdig_next[nfd_reg] = rem[3:0];
                    work_next          = quot;
                    nfd_next           = nfd_reg + 4'd1;
                end
            end
            F_YEAR:
            begin
                ydig_next[ycnt_reg] = rem[3:0];
                work_next           = quot;
                ycnt_next           = ycnt_reg + 2'd1;
                if (ycnt_reg == 2'(YEAR_DIGITS - 1))
                begin
                    state_next = F_PUSH;
                end
            end
            F_PUSH:
            begin
                if (!job_full)
                begin
                    job_push   = 1'b1;
                    state_next = F_IDLE;
                end
            end
            default:
            begin
                state_next = F_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
            nfd_reg   <= 4'd0;
            ycnt_reg  <= 2'd0;
        end
        else
        begin
            state_reg <= state_next;
            nfd_reg   <= nfd_next;
            ycnt_reg  <= ycnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rec_reg  <= rec_next;
        work_reg <= work_next;
        fdig_reg <= fdig_next;
        ydig_reg <= ydig_next;
    end

    `DGTE_ASSERT_NEXT(a_accept_starts_frac, clk, rst_n, (state_reg == F_IDLE && push), (state_reg == F_FRAC && nfd_reg == 4'd0), "accepted record did not start digit split")
    `DGTE_ASSERT_IMPLY(a_frac_digits_bound, clk, rst_n, 1'b1, (nfd_reg <= 4'(FRAC_DIGITS)), "fraction digit count overran")
    `DGTE_ASSERT_IMPLY(a_job_length_range, clk, rst_n, job_push, (job.total >= 6'd17 && job.total <= 6'd32), "encoded length out of range")

endmodule

// ===== rtl/dgte_job_q.sv =====
// Short queue of classified records between the front and the serialiser.
// Depends on dgte_pkg for the record type.
module dgte_job_q #(
    parameter int DEPTH = 2
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  dgte_pkg::job_t din,
    output logic           full,
    input  logic           pop,
    output dgte_pkg::job_t dout,
    output logic           empty
);
    import dgte_pkg::*;

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    job_t             slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push;
    logic             do_pop;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign dout    = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= din;
        end
    end

endmodule

// ===== rtl/dgte_back.sv =====
// Back part: walks one classified record byte by byte into the result
// register. Depends on dgte_pkg.
`include "assert_macros.svh"
module dgte_back (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                job_empty,
    input  dgte_pkg::job_t      job_in,
    output logic                job_pop,
    output logic                empty,
    input  logic                pop,
    output dgte_pkg::out_item_t result
);
    import dgte_pkg::*;

    back_state_t state_reg, state_next;
    job_t        job_reg, job_next;
    logic [4:0]  pos_reg, pos_next;
    out_item_t   out_reg, out_next;
    logic        out_valid_reg, out_valid_next;

    logic       load_out;
    logic       last_c;
    logic [7:0] byte_c;
    logic [4:0] tail_pos;
    logic [4:0] tail_k;
    logic [4:0] pair_off;
    logic [4:0] year_off;
    logic [4:0] frac_off;
    logic [3:0] frac_idx;
    logic [6:0] pair_val;
    logic [7:0] pair_dig;
    logic [7:0] ohh_dig;
    logic [7:0] omm_dig;
    logic [5:0] body_len;

    assign load_out = (state_reg == B_EMIT) && (!out_valid_reg || pop);
    assign last_c   = job_reg.too_short || (6'(pos_reg) == (job_reg.total - 6'd1));
    assign tail_pos = POS_DOT + (job_reg.has_frac ? (5'(job_reg.frac_cnt) + 5'd1) : 5'd0);
    assign tail_k   = pos_reg - tail_pos;
    assign pair_off = pos_reg - POS_PAIRS;
    assign year_off = 5'd5 - pos_reg;
    assign frac_off = pos_reg - POS_FRAC;
    assign frac_idx = job_reg.frac_cnt - 4'd1 - frac_off[3:0];
    assign ohh_dig  = two_digits(job_reg.off_hours);
    assign omm_dig  = two_digits(job_reg.off_minutes);
    assign pair_dig = two_digits(pair_val);
    assign body_len = job_reg.total - 6'd2;

    always_comb
    begin
        case (pair_off[3:1])
            3'd0:    pair_val = job_reg.month;
            3'd1:    pair_val = job_reg.day;
            3'd2:    pair_val = job_reg.hour;
            3'd3:    pair_val = job_reg.minute;
            default: pair_val = job_reg.second;
        endcase
    end

    // Pick the byte for the current position.
    always_comb
    begin
        if (job_reg.too_short)
        begin
            byte_c = 8'h00;
        end
        else if (pos_reg == POS_TAG)
        begin
            byte_c = TAG_GENTIME;
        end
        else if (pos_reg == POS_LEN)
        begin
            byte_c = {2'b00, body_len};
        end
        else if (pos_reg < POS_PAIRS)
        begin
            byte_c = digit_char(job_reg.year_dig[year_off[1:0]]);
        end
        else if (pos_reg < POS_DOT)
        begin
            byte_c = digit_char(pair_off[0] ? pair_dig[3:0] : pair_dig[7:4]);
        end
        else if (pos_reg >= tail_pos)
        begin
            case (tail_k)
                5'd0:
                    byte_c = !job_reg.has_off ? ASCII_Z
                           : (job_reg.off_neg ? ASCII_MINUS : ASCII_PLUS);
                5'd1:    byte_c = digit_char(ohh_dig[7:4]);
                5'd2:    byte_c = digit_char(ohh_dig[3:0]);
                5'd3:    byte_c = digit_char(omm_dig[7:4]);
                default: byte_c = digit_char(omm_dig[3:0]);
            endcase
        end
        else if (pos_reg == POS_DOT)
        begin
            byte_c = ASCII_DOT;
        end
        else
        begin
            byte_c = digit_char(job_reg.frac_dig[frac_idx]);
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        job_next       = job_reg;
        pos_next       = pos_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg;
        job_pop        = 1'b0;
        if (pop && out_valid_reg)
        begin
            out_valid_next = 1'b0;
        end
        case (state_reg)
            B_IDLE:
            begin
                if (!job_empty)
                begin
                    job_pop    = 1'b1;
                    job_next   = job_in;
                    pos_next   = 5'd0;
                    state_next = B_EMIT;
                end
            end
            B_EMIT:
            begin
                if (load_out)
                begin
                    out_next.out_byte     = byte_c;
                    out_next.last         = last_c;
                    out_next.status       = job_reg.too_short ? STATUS_SHORT : STATUS_OK;
                    out_next.total_length = job_reg.total;
                    out_valid_next        = 1'b1;
                    pos_next              = pos_reg + 5'd1;
                    if (last_c)
                    begin
                        state_next = B_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

    assign empty  = !out_valid_reg;
    assign result = out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            out_valid_reg <= 1'b0;
            pos_reg       <= 5'd0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            pos_reg       <= pos_next;
        end
    end

    always_ff @(posedge clk)
    begin
        job_reg <= job_next;
        out_reg <= out_next;
    end

    `DGTE_ASSERT_IMPLY(a_short_is_single, clk, rst_n, (!empty && result.status == STATUS_SHORT), (result.last && result.out_byte == 8'h00), "error beat not a lone zero byte")
    `DGTE_ASSERT_IMPLY(a_pos_in_record, clk, rst_n, (state_reg == B_EMIT), (6'(pos_reg) < job_reg.total), "byte position ran past the record")
    `DGTE_ASSERT_NEXT(a_last_ends_record, clk, rst_n, (load_out && last_c), (state_reg == B_IDLE), "serialiser kept going after the last byte")

endmodule

// ===== rtl/der_generalized_time_encoder.sv =====
// Top level of the DER GeneralizedTime encoder: front, record queue, back.
// Depends on dgte_pkg, dgte_front, dgte_job_q, dgte_back.
//
//  channel | handshake   | payload             | beat
//  --------+-------------+---------------------+------------------
//  input   | push / full | item   (in_item_t)  | one time record
//  result  | pop / empty | result (out_item_t) | one encoded byte
//
// Front: per record it peels the fraction digits, then the four year digits, then
// hands over, all on a single divide-by-ten step, and takes no new record till done.
// Back: after picking up a record, one byte a cycle while the result side takes
// them; a length error gives a single zero beat.
// Reset clears all control state. A stalled result side fills the record queue,
// then holds the front, then raises full; nothing is dropped.
module der_generalized_time_encoder #(
    parameter int JOB_DEPTH = 2
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    output logic                full,
    input  dgte_pkg::in_item_t  item,
    output logic                empty,
    input  logic                pop,
    output dgte_pkg::out_item_t result
);
    import dgte_pkg::*;

    // Classified records on their way to the serialiser.
    job_t q_in;
    job_t q_out;
    logic q_push;
    logic q_full;
    logic q_pop;
    logic q_empty;

    // Split digits and size the encoding; hold while the queue is full.
    dgte_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .full     (full),
        .item     (item),
        .job_push (q_push),
        .job      (q_in),
        .job_full (q_full)
    );

    dgte_job_q #(
        .DEPTH (JOB_DEPTH)
    ) u_job_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (q_push),
        .din   (q_in),
        .full  (q_full),
        .pop   (q_pop),
        .dout  (q_out),
        .empty (q_empty)
    );

    // Advance one byte per free result slot.
    dgte_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_empty (q_empty),
        .job_in    (q_out),
        .job_pop   (q_pop),
        .empty     (empty),
        .pop       (pop),
        .result    (result)
    );

endmodule

// ===== test/der_generalized_time_encoder_tb.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for der_generalized_time_encoder: directed and random time records.
// Depends on dgte_pkg and the encoder RTL; the expected DER bytes are predicted here.
module der_generalized_time_encoder_tb;

    import dgte_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int LONG_HOLD   = 400;   // cycles the result side holds off under pressure
    localparam int PHASE_ITEMS = 67;

    // Expected encoded bytes, oldest first, with the predictor that fills them.
    class gentime_check;
        out_item_t   bytes_due[$];
        int unsigned mismatches;
        int unsigned beats_seen;

        function logic [7:0] ascii_digit(longint unsigned v);
            return ASCII_ZERO + 8'(v % 10);
        endfunction

        function int unsigned frac_digits(logic [31:0] f);
            int unsigned n;
            n = 0;
            while (f != 0)
            begin
                f = f / 10;
                n++;
            end
            return n;
        endfunction

        // Tag, length byte, 14 time digits, optional '.' and digits, then 'Z' or offset.
        function logic [5:0] encoded_length(in_item_t r);
            int unsigned n;
            n = 16;
            if (r.fraction != 0)
                n += 1 + frac_digits(r.fraction);
            n += (r.offset_hours != 0 || r.offset_minutes != 0) ? 5 : 1;
            return 6'(n);
        endfunction

        function void note_record(in_item_t r);
            logic [7:0]      enc[$];
            logic [6:0]      pairs[5];
            logic [5:0]      len;
            longint unsigned f;
            longint unsigned p10;
            out_item_t       b;
            len = encoded_length(r);
            if (r.buffer_space < len)
            begin
                // Too little room: a single status beat carrying the needed length.
                b.out_byte     = 8'h00;
                b.last         = 1'b1;
                b.status       = STATUS_SHORT;
                b.total_length = len;
                bytes_due.push_back(b);
                return;
            end
            enc.push_back(TAG_GENTIME);
            enc.push_back(8'(len - 2));
            enc.push_back(ascii_digit(r.year / 1000));
            enc.push_back(ascii_digit(r.year / 100));
            enc.push_back(ascii_digit(r.year / 10));
            enc.push_back(ascii_digit(r.year));
            pairs = '{r.month, r.day, r.hour, r.minute, r.second};
            foreach (pairs[k])
            begin
                enc.push_back(ascii_digit(pairs[k] / 10));
                enc.push_back(ascii_digit(pairs[k]));
            end
            if (r.fraction != 0)
            begin
                enc.push_back(ASCII_DOT);
                f   = r.fraction;
                p10 = 1;
                while (p10 * 10 <= f)
                    p10 *= 10;
                while (p10 != 0)
                begin
                    enc.push_back(ascii_digit(f / p10));
                    p10 /= 10;
                end
            end
            if (r.offset_hours != 0 || r.offset_minutes != 0)
            begin
                enc.push_back(r.offset_negative ? ASCII_MINUS : ASCII_PLUS);
                enc.push_back(ascii_digit(r.offset_hours / 10));
                enc.push_back(ascii_digit(r.offset_hours));
                enc.push_back(ascii_digit(r.offset_minutes / 10));
                enc.push_back(ascii_digit(r.offset_minutes));
            end
            else
                enc.push_back(ASCII_Z);
            foreach (enc[i])
            begin
                b.out_byte     = enc[i];
                b.last         = (i == enc.size() - 1);
                b.status       = STATUS_OK;
                b.total_length = len;
                bytes_due.push_back(b);
            end
        endfunction

        task report_mismatch(string what, logic [31:0] got, logic [31:0] want);
            $display("[%0t] beat %0d: %s got %0h want %0h", $time, beats_seen, what,
                     got, want);
            mismatches++;
        endtask

        task check_byte(out_item_t got);
            out_item_t want;
            beats_seen++;
            if (bytes_due.size() == 0)
            begin
                report_mismatch("unexpected beat", 32'(got), 32'h0);
                return;
            end
            want = bytes_due.pop_front();
            if (got.out_byte !== want.out_byte)
                report_mismatch("out_byte", 32'(got.out_byte), 32'(want.out_byte));
            if (got.last !== want.last)
                report_mismatch("last", 32'(got.last), 32'(want.last));
            if (got.status !== want.status)
                report_mismatch("status", 32'(got.status), 32'(want.status));
            if (got.total_length !== want.total_length)
                report_mismatch("total_length", 32'(got.total_length), 32'(want.total_length));
        endtask
    endclass

    logic      clk   = 1'b0;
    logic      rst_n = 1'b0;
    logic      push  = 1'b0;
    logic      pop   = 1'b0;
    in_item_t  item  = '0;
    logic      full;
    logic      empty;
    out_item_t result;

    gentime_check sb = new();

    // Idle percentages per side; the main process sets them per phase.
    int unsigned tx_idle_pct = 0;
    int unsigned rx_idle_pct = 0;
    // A request for one long result-side hold: the receiver acts when the counts differ.
    int unsigned holds_asked = 0;
    int unsigned holds_done  = 0;
    int unsigned cycles      = 0;

    der_generalized_time_encoder u_top (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .full   (full),
        .item   (item),
        .empty  (empty),
        .pop    (pop),
        .result (result)
    );

    always #6 clk = ~clk;

    // Watchdog: a hung handshake ends the run as a failure.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("der_generalized_time_encoder_tb failed");
            $finish;
        end
    end

    function automatic in_item_t make_record(int unsigned yr, int unsigned mo, int unsigned dy,
                                             int unsigned hh, int unsigned mi, int unsigned ss,
                                             logic [31:0] frac, bit neg, int unsigned oh,
                                             int unsigned om, int unsigned space);
        in_item_t r;
        r.year            = 14'(yr);
        r.month           = 7'(mo);
        r.day             = 7'(dy);
        r.hour            = 7'(hh);
        r.minute          = 7'(mi);
        r.second          = 7'(ss);
        r.fraction        = frac;
        r.offset_negative = neg;
        r.offset_hours    = 7'(oh);
        r.offset_minutes  = 7'(om);
        r.buffer_space    = 8'(space);
        return r;
    endfunction

    // Mostly plausible calendar records, some raw field bits; the buffer is mostly
    // roomy, sometimes at or one below the needed length, sometimes anything at all.
    function automatic in_item_t random_record();
        in_item_t        r;
        int unsigned     nd;
        int unsigned     roll;
        longint unsigned lo;
        longint unsigned hi;
        logic [5:0]      len;
        roll = $urandom_range(99);
        if (roll < 80)
        begin
            r = make_record($urandom_range(9999), $urandom_range(12, 1), $urandom_range(31, 1),
                            $urandom_range(23), $urandom_range(59), $urandom_range(59),
                            32'h0, $urandom_range(1), 0, 0, 0);
            if ($urandom_range(2) != 0)
            begin
                r.offset_hours   = 7'($urandom_range(14));
                r.offset_minutes = 7'(($urandom_range(1) != 0) ? 15 * $urandom_range(3)
                                                               : $urandom_range(59));
            end
            nd = $urandom_range(10);
            if (nd != 0)
            begin
                lo = 1;
                repeat (nd - 1) lo *= 10;
                hi = lo * 10 - 1;
                if (hi > 64'hFFFF_FFFF)
                    hi = 64'hFFFF_FFFF;
                r.fraction = $urandom_range(32'(hi), 32'(lo));
            end
        end
        else
        begin
            r = make_record($urandom_range(16383), $urandom_range(127), $urandom_range(127),
                            $urandom_range(127), $urandom_range(127), $urandom_range(127),
                            $urandom(), $urandom_range(1), $urandom_range(127),
                            $urandom_range(127), 0);
            if ($urandom_range(3) == 0)
                r.fraction = 32'h0;
        end
        len  = sb.encoded_length(r);
        roll = $urandom_range(99);
        if (roll < 70)
            r.buffer_space = 8'($urandom_range(255, 32));
        else if (roll < 85)
            r.buffer_space = 8'(len) - 8'($urandom_range(1));
        else
            r.buffer_space = 8'($urandom_range(255));
        return r;
    endfunction

    // Offer records in order; hold push and the payload while full stalls a beat.
    task automatic send_records(input in_item_t recs[$]);
        int unsigned sent;
        sent = 0;
        while (sent < recs.size())
        begin
            @(posedge clk);
            if (push && !full)
            begin
                sb.note_record(item);
                sent++;
            end
            if (push && full)
                ;
            else if (sent < recs.size() && $urandom_range(99) >= tx_idle_pct)
            begin
                push <= 1'b1;
                item <= recs[sent];
            end
            else
                push <= 1'b0;
        end
    endtask

    task automatic wait_drained();
        while (sb.bytes_due.size() != 0)
            @(posedge clk);
    endtask

    // Result side: check each accepted beat, then decide pop for the next edge.
    initial
    begin
        int unsigned hold_left;
        hold_left = 0;
        forever
        begin
            @(posedge clk);
            if (rst_n && pop && !empty)
                sb.check_byte(result);
            if (holds_done != holds_asked)
            begin
                hold_left = LONG_HOLD;
                holds_done++;
            end
            if (hold_left != 0)
            begin
                hold_left--;
                pop <= 1'b0;
            end
            else
                pop <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    initial
    begin
        in_item_t recs[$];
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // Directed records: field extremes, fraction shapes, offset forms and the
        // buffer boundary on both sides.
        tx_idle_pct = 31;
        rx_idle_pct = 50;
        recs.push_back(make_record(0, 0, 0, 0, 0, 0, 32'h0, 0, 0, 0, 255));
        recs.push_back(make_record(9999, 12, 31, 23, 59, 59, 32'hFFFF_FFFF, 1, 99, 99, 255));
        recs.push_back(make_record(16383, 127, 127, 127, 127, 127, 32'hFFFF_FFFF, 1, 127, 127,
                                   255));
        recs.push_back(make_record(2024, 2, 29, 12, 34, 56, 32'd1, 0, 0, 0, 32));
        recs.push_back(make_record(1999, 1, 1, 0, 0, 0, 32'd1000000000, 0, 5, 30, 128));
        recs.push_back(make_record(2000, 6, 15, 8, 9, 10, 32'd10, 0, 0, 1, 64));
        recs.push_back(make_record(1970, 7, 4, 18, 45, 0, 32'h8000_0000, 1, 1, 0, 200));
        // Zero offset with the sign set: the sign must be dropped for 'Z'.
        recs.push_back(make_record(2038, 1, 19, 3, 14, 7, 32'h0, 1, 0, 0, 17));
        recs.push_back(make_record(2038, 1, 19, 3, 14, 7, 32'h0, 0, 0, 0, 16));
        recs.push_back(make_record(9999, 12, 31, 23, 59, 59, 32'hFFFF_FFFF, 0, 12, 0, 0));
        recs.push_back(make_record(9999, 12, 31, 23, 59, 59, 32'd4000000000, 1, 99, 99, 31));
        recs.push_back(make_record(9999, 12, 31, 23, 59, 59, 32'd4000000000, 1, 99, 99, 32));
        // Out-of-range digit fields keep only their low decimal digits.
        recs.push_back(make_record(10000, 100, 0, 99, 100, 101, 32'd9, 0, 100, 100, 255));
        recs.push_back(make_record(12345, 64, 32, 16, 8, 4, 32'd123456789, 1, 64, 1, 160));
        recs.push_back(make_record(1, 1, 1, 1, 1, 1, 32'd7, 1, 14, 45, 22));
        recs.push_back(make_record(8191, 85, 42, 21, 106, 53, 32'h5555_5555, 0, 85, 42, 85));
        send_records(recs);
        wait_drained();

        // Random phases: the receiver idles more first, then the sender, then neither.
        // The last phase also stalls the result side long enough to fill the block.
        for (int ph = 0; ph < 3; ph++)
        begin
            tx_idle_pct = (ph == 0) ? 31 : (ph == 1) ? 50 : 0;
            rx_idle_pct = (ph == 0) ? 50 : (ph == 1) ? 31 : 0;
            if (ph == 2)
                holds_asked++;
            recs.delete();
            repeat (PHASE_ITEMS) recs.push_back(random_record());
            send_records(recs);
            wait_drained();
        end

        // Let any stray beat surface before the verdict.
        repeat (40) @(posedge clk);
        if (sb.mismatches == 0 && sb.bytes_due.size() == 0)
            $display("der_generalized_time_encoder_tb passed");
        else
            $display("der_generalized_time_encoder_tb failed");
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/dgte_pkg.sv
rtl/dgte_front.sv
rtl/dgte_job_q.sv
rtl/dgte_back.sv
rtl/der_generalized_time_encoder.sv
test/der_generalized_time_encoder_tb.sv
